// ===== hdl/rhps_pkg.sv =====
// shared constants and types for the rolling hash pattern search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rhps_pkg;

  localparam int PAT_DEPTH = 32;
  localparam int PTR_W     = $clog2(PAT_DEPTH);
  localparam int LEN_W     = PTR_W + 1;
  localparam int BYTE_W    = 8;
  localparam int HASH_W    = 7;
  localparam int CNT_W     = 24;

  localparam logic [HASH_W-1:0] HASH_BASE = 7'd101;
  localparam logic [HASH_W-1:0] HASH_ONE  = 7'd1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(PAT_DEPTH);

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_TEXT    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_PUSH = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/rolling_hash_pattern_search.sv =====
// rolling hash (rabin-karp) pattern search, top level
// depends on rhps_pkg and rhps_ram
//
// usage:
//   in channel: tuser = action (0 pattern byte, 1 text byte),
//   tdata = char_value and first flag; first restarts pattern or text.
//   out channel: tdata = 1-based start position of a verified match.
//   pattern bytes and text bytes with no pattern are handled in idle.
//   other text bytes then pass the hash and push states: read the leaving
//   window byte from the ring memory, remove its hash term, push the new byte.
//   on a hash hit the window is checked against the pattern store, one
//   byte per cycle through both memory read ports, stopping at the first
//   mismatch; a full match then goes to the done state to post the result.
//   a result sits in the output register until taken; a further match
//   waits in the done state while the receiver stalls, holding off new items.
//   reset clears the pattern length, hashes, text position and ring
//   pointer; the memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rolling_hash_pattern_search
  import rhps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // char_value[7:0], first[8], zero
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // match_position[23:0]
);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [HASH_W-1:0]  ph_r, ph_nxt;
  logic [HASH_W-1:0]  wh_r, wh_nxt;
  logic [HASH_W-1:0]  lp_r, lp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [BYTE_W-1:0]  c_r, c_nxt;
  logic [HASH_W-1:0]  t_r, t_nxt;
  logic [PTR_W-1:0]   slot_r, slot_nxt;
  logic [LEN_W-1:0]   iss_r, iss_nxt;
  logic               chk_r, chk_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   out_pos_r, out_pos_nxt;

  logic               accept;
  logic [BYTE_W-1:0]  in_char;
  logic               in_first;

  logic               pat_we;
  logic [PTR_W-1:0]   pat_waddr;
  logic [PTR_W-1:0]   pat_raddr;
  logic [BYTE_W-1:0]  pat_rd;
  logic               ring_we;
  logic [PTR_W-1:0]   ring_raddr;
  logic [BYTE_W-1:0]  ring_rd;

  logic [LEN_W-1:0]   len_base;
  logic [HASH_W-1:0]  ph_base;
  logic [HASH_W-1:0]  lp_base;
  logic [13:0]        ph_prod;
  logic [13:0]        lp_prod;
  logic [14:0]        lead_prod;
  logic [13:0]        push_prod;
  logic [HASH_W-1:0]  wh_push;
  logic [PTR_W-1:0]   rp_eff;
  logic [PTR_W-1:0]   rp_inc;
  logic [PTR_W-1:0]   slot_inc;
  logic               cnt_full;
  logic               fire_out;

  assign in_char  = in_tdata[7:0];
  assign in_first = in_tdata[8];
  assign accept   = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pos_r;

  rhps_ram u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (in_char),
    .raddr (pat_raddr),
    .rdata (pat_rd)
  );

  rhps_ram u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (rp_r),
    .wdata (c_r),
    .raddr (ring_raddr),
    .rdata (ring_rd)
  );

  // pattern side arithmetic
  assign len_base  = in_first ? '0 : len_r;
  assign ph_base   = in_first ? '0 : ph_r;
  assign lp_base   = in_first ? HASH_ONE : lp_r;
  assign ph_prod   = ph_base * HASH_BASE;
  assign lp_prod   = lp_base * HASH_BASE;
  assign pat_waddr = len_base[PTR_W-1:0];
  assign pat_we    = accept && (in_tuser == ACT_PATTERN) && (len_base < LEN_FULL);
  assign pat_raddr = iss_r[PTR_W-1:0];

  // text side arithmetic
  assign rp_eff     = (in_first || ({1'b0, rp_r} >= len_r)) ? '0 : rp_r;
  assign ring_raddr = (state_r == S_CMP) ? slot_r : rp_eff;
  assign ring_we    = (state_r == S_HASH);
  assign lead_prod  = ring_rd * lp_r;
  assign push_prod  = t_r * HASH_BASE;
  assign wh_push    = push_prod[HASH_W-1:0] + c_r[HASH_W-1:0];
  assign rp_inc     = (({1'b0, rp_r} + LEN_W'(1)) >= len_r) ? '0 : rp_r + PTR_W'(1);
  assign slot_inc   = (({1'b0, slot_r} + LEN_W'(1)) >= len_r) ? '0 : slot_r + PTR_W'(1);
  assign cnt_full   = (cnt_r == CNT_MAX);
  assign fire_out   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ph_nxt        = ph_r;
    wh_nxt        = wh_r;
    lp_nxt        = lp_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    c_nxt         = c_r;
    t_nxt         = t_r;
    slot_nxt      = slot_r;
    iss_nxt       = iss_r;
    chk_nxt       = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          c_nxt = in_char;
          if (in_tuser == ACT_PATTERN) begin
            len_nxt = len_base;
            ph_nxt  = ph_base;
            lp_nxt  = lp_base;
            cnt_nxt = '0;
            wh_nxt  = '0;
            rp_nxt  = '0;
            if (len_base < LEN_FULL) begin
              if (len_base != '0) begin
                lp_nxt = lp_prod[HASH_W-1:0];
              end
              ph_nxt  = ph_prod[HASH_W-1:0] + in_char[HASH_W-1:0];
              len_nxt = len_base + LEN_W'(1);
            end
          end else begin
            if (in_first) begin
              cnt_nxt = '0;
              wh_nxt  = '0;
            end
            if (len_r == '0) begin
              if (in_first) begin
                cnt_nxt = CNT_W'(1);
              end else if (!cnt_full) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              rp_nxt = in_first ? '0 : rp_r;
            end else begin
              rp_nxt    = rp_eff;
              state_nxt = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        // ring_rd holds the byte leaving the window
        if (cnt_r < CNT_W'(len_r)) begin
          t_nxt = wh_r;
        end else begin
          t_nxt = wh_r - lead_prod[HASH_W-1:0];
        end
        rp_nxt = rp_inc;
        if (!cnt_full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        wh_nxt = wh_push;
        if ((cnt_r >= CNT_W'(len_r)) && (wh_push == ph_r)) begin
          slot_nxt  = rp_r;
          iss_nxt   = '0;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CMP: begin
        if (iss_r < len_r) begin
          iss_nxt  = iss_r + LEN_W'(1);
          slot_nxt = slot_inc;
          chk_nxt  = 1'b1;
        end
        if (chk_r) begin
          if (ring_rd != pat_rd) begin
            chk_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else if (iss_r == len_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (fire_out) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cnt_r - CNT_W'(len_r) + CNT_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      ph_r        <= '0;
      wh_r        <= '0;
      lp_r        <= HASH_ONE;
      cnt_r       <= '0;
      rp_r        <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ph_r        <= ph_nxt;
      wh_r        <= wh_nxt;
      lp_r        <= lp_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    t_r       <= t_nxt;
    slot_r    <= slot_nxt;
    iss_r     <= iss_nxt;
    out_pos_r <= out_pos_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/rhps_ram.sv =====
// byte store with one write port and one registered read port
// depends on rhps_pkg
`timescale 1ns / 1ps
`default_nettype none

module rhps_ram
  import rhps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [PTR_W-1:0]  waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic [PTR_W-1:0]  raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [PAT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
